// ----- rtl/tssc_pkg.sv -----
// Shared types and constants for the text screen scrollback block.
// No dependencies.
package tssc_pkg;

  localparam int ROWS_DEF     = 256;
  localparam int MAX_COLS_DEF = 128;
  localparam logic [7:0] COLUMNS_RESET = 8'd80;

  typedef enum logic [4:0] {
    K_WRITE     = 5'd0,
    K_NEWLINE   = 5'd1,
    K_BACKSPACE = 5'd2,
    K_CR        = 5'd3,
    K_LEFT      = 5'd4,
    K_RIGHT     = 5'd5,
    K_UP        = 5'd6,
    K_DOWN      = 5'd7,
    K_POSITION  = 5'd8,
    K_SAVE      = 5'd9,
    K_RESTORE   = 5'd10,
    K_ERASE_DSP = 5'd11,
    K_ERASE_LN  = 5'd12,
    K_CLEAR     = 5'd13,
    K_RESET     = 5'd14,
    K_READ      = 5'd15,
    K_SCROLL    = 5'd16
  } kind_t;

  localparam logic [1:0] EM_TO_END   = 2'd0;
  localparam logic [1:0] EM_TO_START = 2'd1;
  localparam logic [1:0] EM_WHOLE    = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,   // clear sweep over the whole store
    S_IDLE,
    S_SPAN,   // clear a column span of one row
    S_RDWAIT, // memory read in flight
    S_OUT     // result waiting
  } state_t;

  // request from controller to memory
  typedef struct packed {
    logic        we;
    logic        re;
    logic [19:0] addr;
    logic [15:0] wdata;
  } mem_req_t;

endpackage

// ----- rtl/tssc_cell_ram.sv -----
// Cell store: single port synchronous RAM with a registered read.
// Depends on tssc_pkg.
module tssc_cell_ram #(
  parameter int DEPTH = tssc_pkg::ROWS_DEF * tssc_pkg::MAX_COLS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  tssc_pkg::mem_req_t  req,
  output logic [15:0]         rdata
);
  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr[AW-1:0]];
    end
  end
endmodule

// ----- rtl/text_screen_scrollback_cursor.sv -----
// Text screen scrollback store with cursor. An item is accepted in S_IDLE and
// its result beat is offered from S_OUT; a read passes through S_RDWAIT first.
// Erase line, scroll and a wrap past the last row first clear the cells of one
// row in S_SPAN (up to MAX_COLS); clear, erase display in whole mode and reset
// sweep all ROWS*MAX_COLS cells in S_INIT. On rst the registers reset and the same sweep
// zeroes the store before any beat is taken. Depends on tssc_pkg, tssc_cell_ram.
module text_screen_scrollback_cursor #(
  parameter int ROWS     = tssc_pkg::ROWS_DEF,
  parameter int MAX_COLS = tssc_pkg::MAX_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] kind,
  input  logic [7:0] char_code,
  input  logic [3:0] fore_colour,
  input  logic [3:0] back_colour,
  input  logic [1:0] erase_mode,
  input  logic signed [9:0] target_row,
  input  logic signed [8:0] target_col,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] cursor_line,
  output logic [6:0] cursor_column,
  output logic       cursor_shown,
  output logic [7:0] ring_head,
  output logic [7:0] read_char,
  output logic [3:0] read_fore,
  output logic [3:0] read_back
);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int AW = $clog2(ROWS * MAX_COLS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  tssc_pkg::state_t state, state_next;
  logic [7:0]  columns;
  logic [RW-1:0] head_row, cur_row, saved_row;
  logic [CW-1:0] cur_col, saved_col;
  logic visible_flag, saved_visible;
  logic [RW-1:0] head_next, row_next, srow_next;
  logic [CW-1:0] col_next, scol_next;
  logic vis_next, svis_next;
  logic [AW:0]   sweep, sweep_next;
  logic [RW-1:0] span_row, span_row_next;
  logic [CW-1:0] span_end, span_end_next;
  logic [CW-1:0] cols;
  logic          rd_pend, rd_pend_next;
  tssc_pkg::mem_req_t req;
  logic [15:0]   rdata;
  logic [15:0]   rcell;

  tssc_cell_ram #(.DEPTH(ROWS * MAX_COLS), .AW(AW)) u_ram (
    .clk  (clk),
    .req  (req),
    .rdata(rdata)
  );

  always_comb begin
    if (columns == 8'd0) begin
      cols = CW'(1);
    end else if (32'(columns) > MAX_COLS) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(columns);
    end
  end

  function automatic logic [RW-1:0] phys(input logic [RW-1:0] hd, input logic [RW-1:0] lg);
    logic [RW:0] s;
    s = {1'b0, hd} + {1'b0, lg};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  logic [RW-1:0] trow_c;
  logic [CW-1:0] tcol_c;
  always_comb begin
    if (target_row < 0) begin
      trow_c = '0;
    end else if (32'(target_row) >= ROWS) begin
      trow_c = LAST_ROW;
    end else begin
      trow_c = RW'(target_row);
    end
    if (target_col < 0) begin
      tcol_c = '0;
    end else if (32'(target_col) >= 32'(cols)) begin
      tcol_c = cols - CW'(1);
    end else begin
      tcol_c = CW'(target_col);
    end
  end

  assign in_ready  = (state == tssc_pkg::S_IDLE);
  assign out_valid = (state == tssc_pkg::S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tssc_pkg::S_INIT;
      columns <= tssc_pkg::COLUMNS_RESET;
      head_row <= '0; cur_row <= '0; cur_col <= '0;
      visible_flag <= 1'b1;
      saved_row <= '0; saved_col <= '0; saved_visible <= 1'b0;
      sweep <= '0; rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        columns <= cfg_wdata;
      end
      head_row <= head_next; cur_row <= row_next; cur_col <= col_next;
      visible_flag <= vis_next;
      saved_row <= srow_next; saved_col <= scol_next; saved_visible <= svis_next;
      sweep <= sweep_next; rd_pend <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    span_row <= span_row_next;
    span_end <= span_end_next;
    if (rd_pend) begin
      rcell <= rdata;
    end else if (state == tssc_pkg::S_IDLE) begin
      rcell <= '0;
    end
  end

  // marks whether a store sweep belongs to an accepted item (not the power-up sweep)
  logic rd_pend_q_item;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend_q_item <= 1'b0;
    end else if (state == tssc_pkg::S_IDLE && in_valid) begin
      rd_pend_q_item <= 1'b1;
    end else if (state == tssc_pkg::S_OUT) begin
      rd_pend_q_item <= 1'b0;
    end
  end

  // ring scroll flag: a wrap or newline on the last row, or a scroll item
  logic wrap_scroll;
  always_comb begin
    state_next = state;
    head_next = head_row; row_next = cur_row; col_next = cur_col;
    vis_next = visible_flag;
    srow_next = saved_row; scol_next = saved_col; svis_next = saved_visible;
    sweep_next = sweep; rd_pend_next = 1'b0;
    span_row_next = span_row; span_end_next = span_end;
    req = '0;
    wrap_scroll = 1'b0;
    unique case (state)
      tssc_pkg::S_INIT: begin
        req.we   = 1'b1;
        req.addr = 20'(sweep[AW-1:0]);
        if (32'(sweep) == ROWS * MAX_COLS - 1) begin
          sweep_next = '0;
          // after the power-up sweep there is no item to answer
          state_next = rd_pend_q_item ? tssc_pkg::S_OUT : tssc_pkg::S_IDLE;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      tssc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = tssc_pkg::S_OUT;
          unique case (kind)
            tssc_pkg::K_WRITE: begin
              if (32'(cur_col) < MAX_COLS) begin
                req.we    = 1'b1;
                req.addr  = 20'(cell_addr(phys(head_row, cur_row), cur_col));
                req.wdata = {back_colour, fore_colour, char_code};
              end
              if (cur_col + CW'(1) >= cols) begin
                col_next = '0;
                wrap_scroll = (cur_row == LAST_ROW);
                if (!wrap_scroll) row_next = cur_row + 1'b1;
              end else begin
                col_next = cur_col + 1'b1;
              end
            end
            tssc_pkg::K_NEWLINE: begin
              col_next = '0;
              wrap_scroll = (cur_row == LAST_ROW);
              if (!wrap_scroll) row_next = cur_row + 1'b1;
            end
            tssc_pkg::K_BACKSPACE: begin
              if (cur_col != '0) begin
                col_next = cur_col - 1'b1;
              end else if (cur_row != '0) begin
                row_next = cur_row - 1'b1;
                col_next = cols - CW'(1);
              end
            end
            tssc_pkg::K_CR: col_next = '0;
            tssc_pkg::K_LEFT: if (cur_col != '0) col_next = cur_col - 1'b1;
            tssc_pkg::K_RIGHT: if (cur_col + CW'(1) < cols) col_next = cur_col + 1'b1;
            tssc_pkg::K_UP: if (cur_row != '0) row_next = cur_row - 1'b1;
            tssc_pkg::K_DOWN: if (cur_row != LAST_ROW) row_next = cur_row + 1'b1;
            tssc_pkg::K_POSITION: begin
              row_next = trow_c; col_next = tcol_c;
            end
            tssc_pkg::K_SAVE: begin
              srow_next = cur_row; scol_next = cur_col; svis_next = visible_flag;
            end
            tssc_pkg::K_RESTORE: begin
              row_next = saved_row; col_next = saved_col; vis_next = saved_visible;
            end
            tssc_pkg::K_ERASE_DSP, tssc_pkg::K_CLEAR, tssc_pkg::K_RESET: begin
              if (kind != tssc_pkg::K_ERASE_DSP || erase_mode == tssc_pkg::EM_WHOLE) begin
                head_next = '0; row_next = '0; col_next = '0;
                if (kind == tssc_pkg::K_RESET) vis_next = 1'b1;
                sweep_next = '0;
                state_next = tssc_pkg::S_INIT;
              end
            end
            tssc_pkg::K_ERASE_LN: begin
              span_row_next = phys(head_row, cur_row);
              // sweep holds the start column, span_end the stop column
              if (erase_mode == tssc_pkg::EM_WHOLE) begin
                sweep_next = '0; span_end_next = cols;
                state_next = tssc_pkg::S_SPAN;
              end else if (erase_mode == tssc_pkg::EM_TO_END) begin
                sweep_next = (AW+1)'(cur_col); span_end_next = cols;
                if (cur_col < cols) state_next = tssc_pkg::S_SPAN;
              end else if (erase_mode == tssc_pkg::EM_TO_START) begin
                sweep_next = '0;
                span_end_next = (cur_col < cols) ? cur_col : cols;
                if (cur_col != '0) state_next = tssc_pkg::S_SPAN;
              end
            end
            tssc_pkg::K_READ: begin
              req.re   = 1'b1;
              req.addr = 20'(cell_addr(phys(head_row, trow_c), tcol_c));
              rd_pend_next = 1'b1;
              state_next = tssc_pkg::S_RDWAIT;
            end
            tssc_pkg::K_SCROLL: wrap_scroll = 1'b1;
            default: ;
          endcase
          if (wrap_scroll) begin
            // advance the head now, then clear the old head row
            span_row_next = head_row;
            head_next = (head_row == LAST_ROW) ? '0 : head_row + 1'b1;
            sweep_next = '0; span_end_next = CW'(MAX_COLS);
            state_next = tssc_pkg::S_SPAN;
          end
        end
      end
      tssc_pkg::S_SPAN: begin
        req.we   = 1'b1;
        req.addr = 20'(cell_addr(span_row, sweep[CW-1:0]));
        if (sweep[CW-1:0] + CW'(1) >= span_end) begin
          sweep_next = '0;
          state_next = tssc_pkg::S_OUT;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      tssc_pkg::S_RDWAIT: state_next = tssc_pkg::S_OUT;
      tssc_pkg::S_OUT: begin
        if (out_ready) state_next = tssc_pkg::S_IDLE;
      end
      default: state_next = tssc_pkg::S_IDLE;
    endcase
  end

  assign cursor_line   = 8'(cur_row);
  assign cursor_column = 7'(cur_col);
  assign cursor_shown  = visible_flag;
  assign ring_head     = 8'(head_row);
  assign read_char     = rcell[7:0];
  assign read_fore     = rcell[11:8];
  assign read_back     = rcell[15:12];
endmodule

// ----- rtl/tssc_checker.sv -----
// Port level checks for the text screen scrollback block, bound to the top.
// Depends on text_screen_scrollback_cursor ports only.
module tssc_props (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] cursor_column,
  input logic [7:0] read_char
);
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("took two items at once");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_column))
    else $error("result dropped");
  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(read_char))
    else $error("read data changed while held");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
endmodule

bind text_screen_scrollback_cursor tssc_props u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .cursor_column(cursor_column), .read_char(read_char)
);

// ----- bench/tssc_checker.sv -----
// Checker for the text screen scrollback block: mirrors the cell store and
// cursor state, predicts one result beat per input beat and compares fields.
// Depends on tssc_pkg.
module tssc_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [4:0] kind,
  input  logic [7:0] char_code,
  input  logic [3:0] fore_colour,
  input  logic [3:0] back_colour,
  input  logic [1:0] erase_mode,
  input  logic signed [9:0] target_row,
  input  logic signed [8:0] target_col,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] cursor_line,
  input  logic [6:0] cursor_column,
  input  logic       cursor_shown,
  input  logic [7:0] ring_head,
  input  logic [7:0] read_char,
  input  logic [3:0] read_fore,
  input  logic [3:0] read_back,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS = tssc_pkg::ROWS_DEF;
  localparam int NCOLS = tssc_pkg::MAX_COLS_DEF;

  typedef struct packed {
    logic [7:0] line;
    logic [6:0] col;
    logic       shown;
    logic [7:0] head;
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
  } status_t;

  logic [15:0] screen [NROWS*NCOLS];
  int unsigned head, row, col, vis, sv_row, sv_col, sv_vis, width_reg;
  status_t status_q[$];

  function automatic int unsigned active_cols();
    if (width_reg == 0) return 1;
    if (width_reg > NCOLS) return NCOLS;
    return width_reg;
  endfunction

  function automatic int unsigned clamp(int v, int unsigned n);
    if (v < 0) return 0;
    if (v >= n) return n - 1;
    return v;
  endfunction

  function automatic int unsigned ring_row(int unsigned lr);
    return (head + lr) % NROWS;
  endfunction

  task automatic blank(int unsigned prow, int unsigned from, int unsigned to);
    if (to > NCOLS) to = NCOLS;
    for (int unsigned i = from; i < to; i++) screen[prow*NCOLS + i] = '0;
  endtask

  task automatic wipe();
    foreach (screen[i]) screen[i] = '0;
    head = 0; row = 0; col = 0;
  endtask

  task automatic roll();
    int unsigned old;
    old = head;
    head = (head + 1) % NROWS;
    blank(old, 0, NCOLS);
  endtask

  task automatic line_feed();
    col = 0;
    if (row + 1 >= NROWS) begin
      roll();
      row = NROWS - 1;
    end else begin
      row++;
    end
  endtask

  task automatic apply_op();
    int unsigned cols, pr, c;
    logic [15:0] word;
    status_t s;
    cols = active_cols();
    word = '0;
    case (kind)
      tssc_pkg::K_WRITE: begin
        pr = ring_row(row);
        if (col < NCOLS) screen[pr*NCOLS + col] = {back_colour, fore_colour, char_code};
        col++;
        if (col >= cols) line_feed();
      end
      tssc_pkg::K_NEWLINE: line_feed();
      tssc_pkg::K_BACKSPACE: begin
        if (col > 0) col--;
        else if (row > 0) begin
          row--;
          col = cols - 1;
        end
      end
      tssc_pkg::K_CR:    col = 0;
      tssc_pkg::K_LEFT:  if (col > 0) col--;
      tssc_pkg::K_RIGHT: if (col + 1 < cols) col++;
      tssc_pkg::K_UP:    if (row > 0) row--;
      tssc_pkg::K_DOWN:  if (row + 1 < NROWS) row++;
      tssc_pkg::K_POSITION: begin
        row = clamp(target_row, NROWS);
        col = clamp(target_col, cols);
      end
      tssc_pkg::K_SAVE: begin
        sv_row = row; sv_col = col; sv_vis = vis;
      end
      tssc_pkg::K_RESTORE: begin
        row = sv_row; col = sv_col; vis = sv_vis;
      end
      tssc_pkg::K_ERASE_DSP: if (erase_mode == tssc_pkg::EM_WHOLE) wipe();
      tssc_pkg::K_ERASE_LN: begin
        pr = ring_row(row);
        if (erase_mode == tssc_pkg::EM_TO_END || erase_mode == tssc_pkg::EM_WHOLE)
          blank(pr, col, cols);
        if (erase_mode == tssc_pkg::EM_TO_START || erase_mode == tssc_pkg::EM_WHOLE)
          blank(pr, 0, col < cols ? col : cols);
      end
      tssc_pkg::K_CLEAR: wipe();
      tssc_pkg::K_RESET: begin
        wipe();
        vis = 1;
      end
      tssc_pkg::K_READ: begin
        pr = ring_row(clamp(target_row, NROWS));
        c = clamp(target_col, cols);
        word = screen[pr*NCOLS + c];
      end
      tssc_pkg::K_SCROLL: roll();
      default: ;
    endcase
    s.line = row[7:0];
    s.col = col[6:0];
    s.shown = vis[0];
    s.head = head[7:0];
    s.ch = word[7:0];
    s.fg = word[11:8];
    s.bg = word[15:12];
    status_q.push_back(s);
  endtask

  always @(posedge clk) begin
    status_t want, got;
    if (rst) begin
      wipe();
      vis = 1; sv_row = 0; sv_col = 0; sv_vis = 0;
      width_reg = tssc_pkg::COLUMNS_RESET;
      status_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) width_reg = cfg_wdata;
      if (out_valid && out_ready) begin
        got = {cursor_line, cursor_column, cursor_shown, ring_head,
               read_char, read_fore, read_back};
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          want = status_q.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch line %0d/%0d col %0d/%0d shown %0d/%0d head %0d/%0d",
                     $time, want.line, got.line, want.col, got.col,
                     want.shown, got.shown, want.head, got.head);
            $display("%0t:   char %h/%h fore %h/%h back %h/%h (expected/actual)",
                     $time, want.ch, got.ch, want.fg, got.fg, want.bg, got.bg);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) apply_op();
    end
    pending = status_q.size();
  end
endmodule

// ----- bench/tb_text_screen_scrollback_cursor.sv -----
// Testbench top: drives terminal operations and column settings into the
// block, with random idling on both channels. Depends on tssc_pkg, tssc_checker.
module tb_text_screen_scrollback_cursor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 3_000_000;

  logic clk, rst, cfg_we, in_valid, in_ready, out_valid, out_ready;
  logic [7:0] cfg_wdata, char_code, cursor_line, ring_head, read_char;
  logic [4:0] kind;
  logic [3:0] fore_colour, back_colour, read_fore, read_back;
  logic [1:0] erase_mode;
  logic signed [9:0] target_row;
  logic signed [8:0] target_col;
  logic [6:0] cursor_column;
  logic cursor_shown;
  int errors, pending, cycles, idle_pct, sent;

  text_screen_scrollback_cursor dut (.*);
  tssc_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= idle_pct);

  // hold valid and payload until the beat is taken; drop valid only when idling
  task automatic send(logic [4:0] k, logic [7:0] ch, logic [3:0] fg, logic [3:0] bg,
                      logic [1:0] em, logic signed [9:0] tr, logic signed [8:0] tc);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; kind <= k; char_code <= ch; fore_colour <= fg;
    back_colour <= bg; erase_mode <= em; target_row <= tr; target_col <= tc;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic set_columns(logic [7:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (tssc_pkg::MAX_COLS_DEF + 8) @(negedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic rand_op();
    int r;
    logic [4:0] k;
    r = $urandom_range(99);
    if (r < 45) k = tssc_pkg::K_WRITE;
    else if (r < 50) k = tssc_pkg::K_READ;
    else if (r < 97) k = 5'($urandom_range(1, 16));
    else k = 5'($urandom_range(0, 31));
    // rare full-store sweeps: mostly demote to cheap kinds
    if ((k == tssc_pkg::K_CLEAR || k == tssc_pkg::K_RESET || k == tssc_pkg::K_ERASE_DSP)
        && $urandom_range(9) != 0)
      k = tssc_pkg::K_READ;
    send(k, 8'($urandom), 4'($urandom), 4'($urandom), 2'($urandom),
         ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(300)),
         9'($urandom));
  endtask

  initial begin
    logic [7:0] widths[6];
    widths = '{8'd1, 8'd0, 8'd128, 8'd255, 8'd3, 8'd80};
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = '0; in_valid = 1'b0; kind = '0; char_code = '0;
    fore_colour = '0; back_colour = '0; erase_mode = '0; target_row = '0; target_col = '0;
    idle_pct = 13; sent = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, every kind but clear, wrap, backspace at origin, shrinking columns
    send(tssc_pkg::K_BACKSPACE, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_WRITE, 8'hFF, 4'hF, 4'hF, '0, '0, '0);
    send(tssc_pkg::K_READ, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_POSITION, '0, '0, '0, '0, 10'sd511, 9'sd255);
    send(tssc_pkg::K_WRITE, 8'h41, 4'h1, 4'h2, '0, '0, '0);
    send(tssc_pkg::K_NEWLINE, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_READ, '0, '0, '0, '0, 10'sd255, 9'sd79);
    send(tssc_pkg::K_POSITION, '0, '0, '0, '0, 10'sh200, 9'sh100);
    send(tssc_pkg::K_BACKSPACE, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_SAVE, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_RIGHT, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_DOWN, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_UP, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_LEFT, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_CR, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_RESTORE, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_ERASE_LN, '0, '0, '0, 2'd3, '0, '0);
    send(tssc_pkg::K_ERASE_LN, '0, '0, '0, tssc_pkg::EM_WHOLE, '0, '0);
    send(tssc_pkg::K_ERASE_DSP, '0, '0, '0, tssc_pkg::EM_TO_END, '0, '0);
    send(tssc_pkg::K_SCROLL, '0, '0, '0, '0, '0, '0);
    send(5'd31, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_RESET, '0, '0, '0, '0, '0, '0);
    send(tssc_pkg::K_POSITION, '0, '0, '0, '0, 10'sd3, 9'sd100);
    set_columns(8'd20);
    send(tssc_pkg::K_ERASE_LN, '0, '0, '0, tssc_pkg::EM_TO_END, '0, '0);
    send(tssc_pkg::K_ERASE_LN, '0, '0, '0, tssc_pkg::EM_TO_START, '0, '0);
    send(tssc_pkg::K_WRITE, 8'h5A, 4'h3, 4'h4, '0, '0, '0);
    // random phases over several column settings; one phase without idling
    for (int p = 0; p < 6; p++) begin
      set_columns(widths[p]);
      idle_pct = (p == 2) ? 0 : 13;
      for (int i = 0; i < 240; i++) rand_op();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (tssc_pkg::MAX_COLS_DEF + 8) @(negedge clk);
    $display("sent %0d operations over six column settings incl. 0, 1, 128 and 255", sent);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ----- text_screen_scrollback_cursor.f -----
rtl/tssc_pkg.sv
rtl/tssc_cell_ram.sv
rtl/text_screen_scrollback_cursor.sv
rtl/tssc_checker.sv
bench/tssc_checker.sv
bench/tb_text_screen_scrollback_cursor.sv
